// ----- src/trz_pkg.sv -----
package trz_pkg;

  localparam int SCREEN_WIDTH      = 128;
  localparam int SCREEN_HEIGHT     = 128;
  localparam int SAMPLES_PER_PIXEL = 4;
  localparam int PIXEL_COUNT       = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int SAMPLE_COUNT      = PIXEL_COUNT * SAMPLES_PER_PIXEL;
  localparam int PIX_AW            = $clog2(PIXEL_COUNT);
  localparam int SMP_AW            = $clog2(SAMPLE_COUNT);

  localparam int VW    = 11;
  localparam int ZW    = 16;
  localparam int CLRW  = 24;
  localparam int CNTW  = 17;
  localparam int CW    = ($clog2(SCREEN_WIDTH + 1) > VW - 4) ? $clog2(SCREEN_WIDTH + 1) : VW - 4;
  localparam int RW    = ($clog2(SCREEN_HEIGHT + 1) > VW - 4) ? $clog2(SCREEN_HEIGHT + 1) : VW - 4;
  localparam int PW    = ((CW > RW) ? CW : RW) + 4;
  localparam int DW    = ((PW > VW) ? PW : VW) + 1;
  localparam int PRW   = VW + 1 + DW;
  localparam int EW    = PRW + 1;
  localparam int AREAW = EW + 2;
  localparam int NUMW  = EW + ZW + 2;
  localparam int QW    = ZW + 1;
  localparam int DIVW  = NUMW + 1;
  localparam int STEPW = $clog2(QW);

  localparam int S_TDATA_W = 144;
  localparam int M_TDATA_W = 48;
  localparam int CFG_AW    = 3;

  localparam logic [1:0] REQ_DRAW  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [CFG_AW-3:0] REG_SS_IDX = '0;

  typedef struct packed {
    logic             load;
    logic             sweep_start;
    logic             sweep_step;
    logic             sweep_init;
    logic             box;
    logic             next_col;
    logic             next_row;
    logic             sub_inc;
    logic             edge_step;
    logic             test;
    logic             zmul_step;
    logic             num_fin;
    logic             div_step;
    logic             dep_commit;
    logic             res_step;
    logic             res_write;
    logic             out_load;
    logic [STEPW-1:0] step;
  } trz_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic [1:0] mask;
    logic       sweep_last;
    logic       col_done;
    logic       row_done;
    logic       sub_last;
    logic       covered;
    logic       ss;
    logic       out_busy;
  } trz_stat_t;

endpackage

// ----- src/trz_ram.sv -----
module trz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/trz_ctrl.sv -----
module trz_ctrl
  import trz_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  trz_stat_t stat,
  output trz_cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_INIT = 16'h0001,
    S_IDLE = 16'h0002,
    S_DEC  = 16'h0004,
    S_CLR  = 16'h0008,
    S_BOX  = 16'h0010,
    S_PIX  = 16'h0020,
    S_EDGE = 16'h0040,
    S_TEST = 16'h0080,
    S_ZMUL = 16'h0100,
    S_NUMF = 16'h0200,
    S_DIV  = 16'h0400,
    S_DEP  = 16'h0800,
    S_NEXT = 16'h1000,
    S_RES  = 16'h2000,
    S_RESW = 16'h4000,
    S_DONE = 16'h8000
  } state_t;

  localparam logic [STEPW-1:0] EDGE_LAST = STEPW'(3);
  localparam logic [STEPW-1:0] ZMUL_LAST = STEPW'(3);
  localparam logic [STEPW-1:0] RES_LAST  = STEPW'(4);
  localparam logic [STEPW-1:0] DIV_LAST  = STEPW'(QW - 1);

  state_t           state, state_next;
  logic [STEPW-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.step   = step;
    state_next = state;
    step_next  = step;
    case (state)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_init = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.req)
          REQ_DRAW: state_next = S_BOX;
          REQ_CLEAR: begin
            if (stat.mask != 2'b00) begin
              cmd.sweep_start = 1'b1;
              state_next      = S_CLR;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_CLR: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_BOX: begin
        cmd.box    = 1'b1;
        state_next = S_PIX;
      end
      S_PIX: begin
        if (stat.col_done) begin
          state_next = S_DONE;
        end else if (stat.row_done) begin
          cmd.next_col = 1'b1;
        end else begin
          step_next  = '0;
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_step = 1'b1;
        if (step == EDGE_LAST) begin
          step_next  = '0;
          state_next = S_TEST;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_TEST: begin
        cmd.test = 1'b1;
        if (stat.covered) begin
          step_next  = '0;
          state_next = S_ZMUL;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_ZMUL: begin
        cmd.zmul_step = 1'b1;
        if (step == ZMUL_LAST) begin
          state_next = S_NUMF;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_NUMF: begin
        cmd.num_fin = 1'b1;
        step_next   = '0;
        state_next  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == DIV_LAST) begin
          state_next = S_DEP;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DEP: begin
        cmd.dep_commit = 1'b1;
        state_next     = S_NEXT;
      end
      S_NEXT: begin
        step_next = '0;
        if (stat.ss && !stat.sub_last) begin
          cmd.sub_inc = 1'b1;
          state_next  = S_EDGE;
        end else if (stat.ss) begin
          state_next = S_RES;
        end else begin
          cmd.next_row = 1'b1;
          state_next   = S_PIX;
        end
      end
      S_RES: begin
        cmd.res_step = 1'b1;
        if (step == RES_LAST) begin
          state_next = S_RESW;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_RESW: begin
        cmd.res_write = 1'b1;
        cmd.next_row  = 1'b1;
        state_next    = S_PIX;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ----- src/trz_dp.sv -----
module trz_dp
  import trz_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  trz_cmd_t             cmd,
  output trz_stat_t            stat,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata
);

  logic [1:0]      req;
  logic [VW-1:0]   vx [3];
  logic [VW-1:0]   vy [3];
  logic [ZW-1:0]   vz [3];
  logic [CLRW-1:0] color;
  logic [1:0]      mask;
  logic            ss;

  logic [CW-1:0]     i, xlim, xlim_next;
  logic [RW-1:0]     j, jmin, ylim, ylim_next;
  logic [1:0]        sub;
  logic [SMP_AW-1:0] sweep;
  logic [VW-1:0]     xmn, xmx, ymn, ymx;

  logic [PIX_AW-1:0] pix, rd_pix;
  logic [SMP_AW-1:0] smp;
  logic [PW-1:0]     px, py;
  logic [3:0]        offx, offy;
  logic              in_range;

  logic [1:0]              es, ea, eb;
  logic signed [VW:0]      dxe, dye;
  logic signed [DW-1:0]    pxa, pya;
  logic signed [PRW-1:0]   pa, pb;
  logic signed [EW-1:0]    e [3];
  logic [AREAW-1:0]        area;
  logic [EW+ZW-1:0]        zp;
  logic [NUMW-1:0]         num;
  logic [DIVW-1:0]         rem, dv;
  logic [QW-1:0]           q;
  logic [ZW-1:0]           zq, zold;
  logic                    pass;
  logic [CNTW-1:0]         cnt;
  logic [9:0]              sr, sg, sb;

  logic              fr_we, pd_we, sd_we, sc_we;
  logic [PIX_AW-1:0] fr_wa, pd_wa;
  logic [SMP_AW-1:0] sd_wa, sc_wa;
  logic [CLRW-1:0]   fr_wd, sc_wd, fr_rd, sc_rd;
  logic [ZW-1:0]     pd_wd, sd_wd, pd_rd, sd_rd;
  logic              sw_pix, sw_frame, sw_depth;
  logic              cfg_wr, cfg_sel;

  assign cfg_sel = (paddr[CFG_AW-1:2] == REG_SS_IDX);
  assign cfg_wr  = psel & penable & pwrite & cfg_sel;
  assign prdata  = cfg_sel ? {31'b0, ss} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ss <= 1'b0;
    end else if (cfg_wr) begin
      ss <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= s_tuser;
      vx[0] <= s_tdata[10:0];
      vy[0] <= s_tdata[21:11];
      vz[0] <= s_tdata[37:22];
      vx[1] <= s_tdata[48:38];
      vy[1] <= s_tdata[59:49];
      vz[1] <= s_tdata[75:60];
      vx[2] <= s_tdata[86:76];
      vy[2] <= s_tdata[97:87];
      vz[2] <= s_tdata[113:98];
      color <= s_tdata[137:114];
      mask  <= s_tdata[139:138];
    end
  end

  always_comb begin
    xmn = vx[0];
    xmx = vx[0];
    ymn = vy[0];
    ymx = vy[0];
    for (int k = 1; k < 3; k++) begin
      if (vx[k] < xmn) xmn = vx[k];
      if (vx[k] > xmx) xmx = vx[k];
      if (vy[k] < ymn) ymn = vy[k];
      if (vy[k] > ymx) ymx = vy[k];
    end
    xlim_next = (CW'(xmx[VW-1:4]) > CW'(SCREEN_WIDTH)) ? CW'(SCREEN_WIDTH) : CW'(xmx[VW-1:4]);
    ylim_next = (RW'(ymx[VW-1:4]) > RW'(SCREEN_HEIGHT)) ? RW'(SCREEN_HEIGHT) : RW'(ymx[VW-1:4]);
  end

  always_ff @(posedge clk) begin
    if (cmd.box) begin
      i    <= CW'(xmn[VW-1:4]);
      j    <= RW'(ymn[VW-1:4]);
      jmin <= RW'(ymn[VW-1:4]);
      xlim <= xlim_next;
      ylim <= ylim_next;
      sub  <= 2'd0;
    end else if (cmd.next_col) begin
      i   <= i + 1'b1;
      j   <= jmin;
      sub <= 2'd0;
    end else if (cmd.next_row) begin
      j   <= j + 1'b1;
      sub <= 2'd0;
    end else if (cmd.sub_inc) begin
      sub <= sub + 1'b1;
    end
  end

  assign pix      = PIX_AW'(j) * PIX_AW'(SCREEN_WIDTH) + PIX_AW'(i);
  assign smp      = {pix, sub};
  assign rd_pix   = PIX_AW'(vy[0]) * PIX_AW'(SCREEN_WIDTH) + PIX_AW'(vx[0]);
  assign in_range = (32'(vx[0]) < SCREEN_WIDTH) && (32'(vy[0]) < SCREEN_HEIGHT);
  assign offx     = ss ? (sub[1] ? 4'd12 : 4'd4) : 4'd8;
  assign offy     = ss ? (sub[0] ? 4'd12 : 4'd4) : 4'd8;
  assign px       = PW'({i, 4'b0000}) + PW'(offx);
  assign py       = PW'({j, 4'b0000}) + PW'(offy);

  assign es = cmd.step[1:0];

  always_comb begin
    case (es)
      2'd0: begin
        ea = 2'd1;
        eb = 2'd2;
      end
      2'd1: begin
        ea = 2'd2;
        eb = 2'd0;
      end
      default: begin
        ea = 2'd0;
        eb = 2'd1;
      end
    endcase
    dxe = $signed({1'b0, vx[eb]}) - $signed({1'b0, vx[ea]});
    dye = $signed({1'b0, vy[eb]}) - $signed({1'b0, vy[ea]});
    pxa = $signed(DW'(px)) - $signed(DW'(vx[ea]));
    pya = $signed(DW'(py)) - $signed(DW'(vy[ea]));
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_step) begin
      pa <= dxe * pya;
      pb <= dye * pxa;
      if (es != 2'd0) begin
        e[es - 2'd1] <= pa - pb;
      end
    end
  end

  assign stat.covered = (e[0] > 0) && (e[1] > 0) && (e[2] > 0);

  assign zq   = q[QW-1] ? {ZW{1'b1}} : q[ZW-1:0];
  assign zold = ss ? sd_rd : pd_rd;
  assign pass = zold > zq;

  always_ff @(posedge clk) begin
    if (cmd.test) begin
      area <= AREAW'($unsigned(e[0])) + AREAW'($unsigned(e[1])) + AREAW'($unsigned(e[2]));
      num  <= '0;
    end else if (cmd.zmul_step) begin
      if (es != 2'd3) begin
        zp <= $unsigned(e[es]) * vz[es];
      end
      if (es != 2'd0) begin
        num <= num + NUMW'(zp);
      end
    end
    if (cmd.num_fin) begin
      rem <= DIVW'(num) + DIVW'(area >> 1);
      dv  <= DIVW'(area) << (QW - 1);
      q   <= '0;
    end else if (cmd.div_step) begin
      if (rem >= dv) begin
        rem <= rem - dv;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        q <= {q[QW-2:0], 1'b0};
      end
      dv <= dv >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.dep_commit && pass) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_step) begin
      if (cmd.step == '0) begin
        sr <= '0;
        sg <= '0;
        sb <= '0;
      end else begin
        sr <= sr + 10'(sc_rd[23:16]);
        sg <= sg + 10'(sc_rd[15:8]);
        sb <= sb + 10'(sc_rd[7:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_start) begin
      sweep <= '0;
    end else if (cmd.sweep_step) begin
      sweep <= sweep + 1'b1;
    end
  end

  assign stat.sweep_last = (sweep == SMP_AW'(SAMPLE_COUNT - 1));

  assign sw_pix   = cmd.sweep_step && (sweep < SMP_AW'(PIXEL_COUNT));
  assign sw_frame = cmd.sweep_step && (cmd.sweep_init || mask[0]);
  assign sw_depth = cmd.sweep_step && (cmd.sweep_init || mask[1]);

  always_comb begin
    fr_we = (sw_frame && sw_pix) || (cmd.dep_commit && pass && !ss) || cmd.res_write;
    fr_wa = cmd.sweep_step ? sweep[PIX_AW-1:0] : pix;
    fr_wd = cmd.sweep_step ? '0 : (cmd.res_write ? {sr[9:2], sg[9:2], sb[9:2]} : color);
    pd_we = (sw_depth && sw_pix) || (cmd.dep_commit && pass && !ss);
    pd_wa = cmd.sweep_step ? sweep[PIX_AW-1:0] : pix;
    pd_wd = cmd.sweep_step ? {ZW{1'b1}} : zq;
    sd_we = sw_depth || (cmd.dep_commit && pass && ss);
    sd_wa = cmd.sweep_step ? sweep : smp;
    sd_wd = cmd.sweep_step ? {ZW{1'b1}} : zq;
    sc_we = (cmd.sweep_step && cmd.sweep_init) || (cmd.dep_commit && pass && ss);
    sc_wa = cmd.sweep_step ? sweep : smp;
    sc_wd = cmd.sweep_step ? '0 : color;
  end

  trz_ram #(.WIDTH(CLRW), .DEPTH(PIXEL_COUNT)) u_frame (
    .clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(rd_pix), .rdata(fr_rd)
  );

  trz_ram #(.WIDTH(ZW), .DEPTH(PIXEL_COUNT)) u_pdepth (
    .clk(clk), .we(pd_we), .waddr(pd_wa), .wdata(pd_wd), .raddr(pix), .rdata(pd_rd)
  );

  trz_ram #(.WIDTH(ZW), .DEPTH(SAMPLE_COUNT)) u_sdepth (
    .clk(clk), .we(sd_we), .waddr(sd_wa), .wdata(sd_wd), .raddr(smp), .rdata(sd_rd)
  );

  trz_ram #(.WIDTH(CLRW), .DEPTH(SAMPLE_COUNT)) u_scolor (
    .clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr({pix, es}), .rdata(sc_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {(M_TDATA_W - CNTW - CLRW)'(0),
                  (req == REQ_DRAW) ? cnt : CNTW'(0),
                  ((req == REQ_READ) && in_range) ? fr_rd : CLRW'(0)};
    end
  end

  assign stat.req      = req;
  assign stat.mask     = mask;
  assign stat.col_done = (i >= xlim);
  assign stat.row_done = (j >= ylim);
  assign stat.sub_last = (sub == 2'd3);
  assign stat.ss       = ss;
  assign stat.out_busy = m_tvalid & ~m_tready;

endmodule

// ----- src/triangle_rasterizer_zbuffer_top.sv -----
// Channel  Role            Signals
// s_       request in      s_tvalid, s_tready, s_tdata, s_tuser
// m_       result out      m_tvalid, m_tready, m_tdata
// p*       register port   psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One request is worked at a time. A draw tests every sample of its bounding box, runs the
// depth of each covered sample through the 17-step restoring divider, and with 4x
// resolves each pixel by averaging its four samples.
// After reset, a sweep over all samples initializes all stores before s_tready rises.
// The result register lets the next request enter while m_tready is held low.
module triangle_rasterizer_zbuffer_top
  import trz_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // x0, y0, z0, x1, y1, z1, x2, y2, z2, tri_color, clear_mask, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // req_type
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // pixel_color, samples_written, zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  trz_cmd_t  cmd;
  trz_stat_t stat;

  assign pready = 1'b1;

  trz_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready), .stat(stat), .cmd(cmd)
  );

  trz_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata)
  );

endmodule

// ----- src/trz_chk.sv -----
module trz_chk
  import trz_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [CFG_AW-1:0]    paddr,
  input logic [31:0]          pwdata,
  input logic [31:0]          prdata,
  input logic                 pready
);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in work");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[CFG_AW-1:2] == REG_SS_IDX)
    |=> (paddr[CFG_AW-1:2] != REG_SS_IDX) || (prdata == {31'b0, $past(pwdata[0])}))
    else $error("register read does not return the written value");

endmodule

bind triangle_rasterizer_zbuffer_top trz_chk u_chk (.*);

// ----- bench/tb_triangle_rasterizer_zbuffer_top.sv -----
module tb_triangle_rasterizer_zbuffer_top;
  import trz_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;

  typedef struct packed {
    logic [1:0]       req;
    logic [2:0][10:0] vx;
    logic [2:0][10:0] vy;
    logic [2:0][15:0] vz;
    logic [23:0]      color;
    logic [1:0]       mask;
  } raster_req_t;

  typedef struct packed {
    logic [23:0] color;
    logic [16:0] written;
  } raster_res_t;

  class raster_scoreboard;
    logic [23:0] frame[PIXEL_COUNT];
    logic [15:0] pix_depth[PIXEL_COUNT];
    logic [15:0] smp_depth[SAMPLE_COUNT];
    logic [23:0] smp_color[SAMPLE_COUNT];
    bit          ss_mode;
    raster_res_t expected_q[$];
    int          errors;

    function new();
      foreach (frame[i]) begin
        frame[i] = '0;
        pix_depth[i] = '1;
      end
      foreach (smp_depth[i]) begin
        smp_depth[i] = '1;
        smp_color[i] = '0;
      end
      ss_mode = 0;
      errors = 0;
    endfunction

    function longint edge_val(longint ax, longint ay, longint bx, longint by,
                              longint px, longint py);
      return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    function bit covers(raster_req_t r, longint px, longint py, output logic [15:0] z);
      longint e12, e20, e01, area, num;
      e12 = edge_val(r.vx[1], r.vy[1], r.vx[2], r.vy[2], px, py);
      e20 = edge_val(r.vx[2], r.vy[2], r.vx[0], r.vy[0], px, py);
      e01 = edge_val(r.vx[0], r.vy[0], r.vx[1], r.vy[1], px, py);
      z = '1;
      if (e12 <= 0 || e20 <= 0 || e01 <= 0) return 0;
      area = e12 + e20 + e01;
      num = e12 * r.vz[0] + e20 * r.vz[1] + e01 * r.vz[2];
      num = (num + area / 2) / area;
      z = (num > 65535) ? 16'hFFFF : num[15:0];
      return 1;
    endfunction

    function logic [23:0] average(int base);
      logic [23:0] res;
      int sum;
      for (int sh = 0; sh < 24; sh += 8) begin
        sum = 0;
        for (int s = 0; s < 4; s++) sum += (smp_color[base + s] >> sh) & 8'hFF;
        res[sh +: 8] = sum[9:2];
      end
      return res;
    endfunction

    function logic [16:0] draw_count(raster_req_t r);
      longint minx, maxx, miny, maxy;
      int pix, s, cnt;
      logic [15:0] z;
      minx = r.vx[0]; maxx = r.vx[0]; miny = r.vy[0]; maxy = r.vy[0];
      for (int k = 1; k < 3; k++) begin
        if (r.vx[k] < minx) minx = r.vx[k];
        if (r.vx[k] > maxx) maxx = r.vx[k];
        if (r.vy[k] < miny) miny = r.vy[k];
        if (r.vy[k] > maxy) maxy = r.vy[k];
      end
      minx /= 16; maxx /= 16; miny /= 16; maxy /= 16;
      if (maxx > SCREEN_WIDTH) maxx = SCREEN_WIDTH;
      if (maxy > SCREEN_HEIGHT) maxy = SCREEN_HEIGHT;
      cnt = 0;
      for (longint i = minx; i < maxx; i++) begin
        for (longint j = miny; j < maxy; j++) begin
          pix = int'(i + j * SCREEN_WIDTH);
          if (!ss_mode) begin
            if (covers(r, i * 16 + 8, j * 16 + 8, z) && pix_depth[pix] > z) begin
              pix_depth[pix] = z;
              frame[pix] = r.color;
              cnt++;
            end
          end else begin
            for (int hx = 0; hx < 2; hx++) begin
              for (int hy = 0; hy < 2; hy++) begin
                s = pix * 4 + hx * 2 + hy;
                if (covers(r, i * 16 + hx * 8 + 4, j * 16 + hy * 8 + 4, z) &&
                    smp_depth[s] > z) begin
                  smp_depth[s] = z;
                  smp_color[s] = r.color;
                  cnt++;
                end
              end
            end
            frame[pix] = average(pix * 4);
          end
        end
      end
      return cnt[16:0];
    endfunction

    function void note_request(raster_req_t r);
      raster_res_t res;
      res = '0;
      case (r.req)
        REQ_DRAW: res.written = draw_count(r);
        REQ_READ: begin
          if (r.vx[0] < SCREEN_WIDTH && r.vy[0] < SCREEN_HEIGHT)
            res.color = frame[r.vx[0] + r.vy[0] * SCREEN_WIDTH];
        end
        REQ_CLEAR: begin
          if (r.mask[0]) foreach (frame[i]) frame[i] = '0;
          if (r.mask[1]) begin
            foreach (pix_depth[i]) pix_depth[i] = '1;
            foreach (smp_depth[i]) smp_depth[i] = '1;
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    function void report(string what, logic [47:0] exp_v, logic [47:0] act_v);
      errors++;
      if (errors <= 10)
        $display("Mismatch in %s: expected %h, got %h", what, exp_v, act_v);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
      raster_res_t res;
      if (expected_q.size() == 0) begin
        report("unexpected transaction", '0, data);
        return;
      end
      res = expected_q.pop_front();
      if (data[23:0] !== res.color) report("pixel_color", res.color, data[23:0]);
      if (data[40:24] !== res.written)
        report("samples_written", res.written, data[40:24]);
      if (data[47:41] !== '0) report("padding", '0, data[47:41]);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_AW-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  raster_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int cycle_count;

  triangle_rasterizer_zbuffer_top dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic send_request(raster_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.req;
    s_tdata <= {4'b0, r.mask, r.color, r.vz[2], r.vy[2], r.vx[2], r.vz[1], r.vy[1],
                r.vx[1], r.vz[0], r.vy[0], r.vx[0]};
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_supersample(bit value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= {31'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== value) sb.report("register readback", value, prdata[0]);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.ss_mode = value;
  endtask

  function automatic raster_req_t make_tri(int x0, int y0, int x1, int y1, int x2,
                                           int y2, int z0, int z1, int z2, int color);
    raster_req_t r;
    r = '0;
    r.req = REQ_DRAW;
    r.vx[0] = x0; r.vy[0] = y0; r.vz[0] = z0;
    r.vx[1] = x1; r.vy[1] = y1; r.vz[1] = z1;
    r.vx[2] = x2; r.vy[2] = y2; r.vz[2] = z2;
    r.color = color;
    return r;
  endfunction

  function automatic raster_req_t make_simple(logic [1:0] req, int x, int y, int mask);
    raster_req_t r;
    r = '0;
    r.req = req;
    r.vx[0] = x;
    r.vy[0] = y;
    r.mask = mask;
    return r;
  endfunction

  function automatic raster_req_t random_request();
    raster_req_t r;
    int pick, bx, by, span;
    pick = $urandom_range(0, 99);
    r.req = REQ_DRAW;
    r.mask = $urandom_range(0, 3);
    r.color = $urandom;
    span = ($urandom_range(0, 3) == 0) ? 512 : 2047;
    bx = $urandom_range(0, span);
    by = $urandom_range(0, span);
    for (int k = 0; k < 3; k++) begin
      r.vx[k] = (bx + $urandom_range(0, 80) > 2047) ? 2047 : bx + $urandom_range(0, 80);
      r.vy[k] = (by + $urandom_range(0, 80) > 2047) ? 2047 : by + $urandom_range(0, 80);
      r.vz[k] = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(30000, 34000);
    end
    if (pick >= 70 && pick < 96) begin
      r.req = REQ_READ;
      if ($urandom_range(0, 3) != 0) begin
        r.vx[0] = $urandom_range(0, span / 16 + 5);
        r.vy[0] = $urandom_range(0, span / 16 + 5);
      end
    end else if (pick >= 96 && pick < 98) begin
      r.req = REQ_CLEAR;
    end else if (pick >= 98) begin
      r.req = 2'd3;
    end
    return r;
  endfunction

  task automatic directed_set();
    send_request(make_simple(REQ_READ, 0, 0, 0));
    send_request(make_tri(0, 0, 64, 0, 0, 64, 1000, 2000, 3000, 24'hFF8040));
    send_request(make_tri(0, 0, 0, 64, 64, 0, 10, 10, 10, 24'h123456));
    send_request(make_tri(0, 0, 32, 32, 64, 64, 5, 5, 5, 24'h00FF00));
    send_request(make_tri(8, 8, 72, 8, 8, 72, 0, 0, 0, 24'h0000FF));
    send_request(make_tri(8, 8, 72, 8, 8, 72, 0, 0, 0, 24'hABCDEF));
    send_request(make_tri(100, 100, 160, 100, 100, 160, 65535, 65535, 65535, 24'hFFFFFF));
    send_request(make_tri(1990, 1990, 2047, 1990, 1990, 2047, 65535, 0, 40000, 24'hFFFFFF));
    send_request(make_simple(REQ_READ, 1, 1, 0));
    send_request(make_simple(REQ_READ, 127, 127, 0));
    send_request(make_simple(REQ_READ, 128, 5, 0));
    send_request(make_simple(REQ_READ, 2047, 2047, 0));
    send_request(make_simple(REQ_CLEAR, 0, 0, 1));
    send_request(make_simple(REQ_READ, 1, 1, 0));
    send_request(make_tri(8, 8, 72, 8, 8, 72, 100, 100, 100, 24'h777777));
    send_request(make_simple(REQ_CLEAR, 0, 0, 2));
    send_request(make_tri(8, 8, 72, 8, 8, 72, 100, 100, 100, 24'h010203));
    send_request(make_simple(REQ_CLEAR, 0, 0, 0));
    send_request(make_simple(2'd3, 1, 1, 3));
    send_request(make_simple(REQ_READ, 2, 1, 0));
    send_request(make_simple(REQ_CLEAR, 0, 0, 3));
  endtask

  initial begin
    int idle_s[4];
    int idle_r[4];
    idle_s = '{0, 62, 0, 34};
    idle_r = '{0, 0, 62, 34};
    sb = new();
    cycle_count = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    set_supersample(1'b0);
    directed_set();
    set_supersample(1'b1);
    directed_set();
    for (int ph = 0; ph < 4; ph++) begin
      set_supersample(ph % 2 == 0);
      send_idle_pct = idle_s[ph];
      recv_stall_pct = idle_r[ph];
      if (ph == 0) hold_left = 3000;
      for (int n = 0; n < 90; n++) send_request(random_request());
    end
    drain();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
